// ===== rtl/cpbf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpbf_pkg
// Shared types, constants and helpers of the column predicate bitmap filter.
// ----------------------------------------------------------------------------
package cpbf_pkg;

  localparam int unsigned Lanes      = 8;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned BlockW     = 13;
  localparam int unsigned CountW     = 17;
  localparam int unsigned CfgIndexW  = 2;

  localparam logic [CfgIndexW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIndexW-1:0] RegCompare   = 2'd1;
  localparam logic [CfgIndexW-1:0] RegCombine   = 2'd2;

  localparam logic [ValueW-1:0] MagMask = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] ExpAll  = 64'h7FF0_0000_0000_0000;
  localparam logic [ValueW-1:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [CountW-1:0] CountMax = 17'h1FFFF;

  typedef struct packed {
    logic [ValueW-1:0] key;
    logic              nan;
    logic              equal_mode;
  } cmp_cfg_t;

  typedef struct packed {
    logic [Lanes-1:0]  mask;
    logic [BlockW-1:0] block;
    logic              in_range;
    logic              pass_start;
  } stage_t;

  function automatic logic is_nan(input logic [ValueW-1:0] x);
    return (x & MagMask) > ExpAll;
  endfunction

  // Monotone unsigned key; both zeros share one key.
  function automatic logic [ValueW-1:0] order_key(input logic [ValueW-1:0] x);
    logic [ValueW-1:0] y;
    y = ((x & MagMask) == '0) ? '0 : x;
    return y[ValueW-1] ? ~y : (y | SignBit);
  endfunction

endpackage

// ===== rtl/column_predicate_bitmap_filter.sv =====
// ----------------------------------------------------------------------------
// column_predicate_bitmap_filter
// Eight-lane double predicate scan with a row bitmap and a running count.
// ----------------------------------------------------------------------------
// Each input is registered in stage 1 and its result in stage 2; one item per cycle while in_stall_o is low.
// Stage 1 runs eight lane compares and reads the bitmap; stage 2 merges.
// After reset all MemDepth (MAX_ROWS/8, at most 8192) bitmap entries are swept to
// all ones; no input is taken meanwhile. Config writes are always taken.
// Reset clears the count and the config registers.
// ----------------------------------------------------------------------------
module column_predicate_bitmap_filter #(
  parameter int unsigned MAX_ROWS = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cpbf_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [63:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cpbf_pkg::BlockW-1:0]         block_index_i,
  input  logic                                pass_start_i,
  input  logic [63:0]                         value0_i,
  input  logic [63:0]                         value1_i,
  input  logic [63:0]                         value2_i,
  input  logic [63:0]                         value3_i,
  input  logic [63:0]                         value4_i,
  input  logic [63:0]                         value5_i,
  input  logic [63:0]                         value6_i,
  input  logic [63:0]                         value7_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          match_mask_o,
  output logic [16:0]                         match_count_o
);

  localparam int unsigned Depth    = MAX_ROWS / 8;
  localparam int unsigned MemDepth = (Depth > 8192) ? 8192 : Depth;
  localparam logic [cpbf_pkg::BlockW:0] DepthLim = (cpbf_pkg::BlockW + 1)'(MemDepth);

  logic [63:0]             thr_q;
  logic                    eq_mode_q;
  logic                    and_mode_q;
  cpbf_pkg::cmp_cfg_t      cmp_cfg;
  logic [63:0]             values [cpbf_pkg::Lanes];
  logic [cpbf_pkg::Lanes-1:0] lane_match;
  cpbf_pkg::stage_t        s1_d;
  cpbf_pkg::stage_t        s1_q;
  logic                    s1_valid_q;
  logic                    out_valid_q;
  logic                    out_adv;
  logic                    s1_adv;
  logic                    in_accept;
  logic                    clearing;
  logic [cpbf_pkg::Lanes-1:0] stored;
  logic [cpbf_pkg::Lanes-1:0] final_mask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      eq_mode_q  <= 1'b0;
      and_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cpbf_pkg::RegThreshold: thr_q      <= cfg_data_i;
        cpbf_pkg::RegCompare:   eq_mode_q  <= cfg_data_i[0];
        cpbf_pkg::RegCombine:   and_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cmp_cfg.key        = cpbf_pkg::order_key(thr_q);
  assign cmp_cfg.nan        = cpbf_pkg::is_nan(thr_q);
  assign cmp_cfg.equal_mode = eq_mode_q;

  assign values[0] = value0_i;
  assign values[1] = value1_i;
  assign values[2] = value2_i;
  assign values[3] = value3_i;
  assign values[4] = value4_i;
  assign values[5] = value5_i;
  assign values[6] = value6_i;
  assign values[7] = value7_i;

  for (genvar g = 0; g < cpbf_pkg::Lanes; g++) begin : g_lane
    cpbf_lane u_lane (
      .value_i (values[g]),
      .cfg_i   (cmp_cfg),
      .match_o (lane_match[g])
    );
  end

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = clearing || (s1_valid_q && !out_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_d.mask       = lane_match;
  assign s1_d.block      = block_index_i;
  assign s1_d.in_range   = ({1'b0, block_index_i} < DepthLim);
  assign s1_d.pass_start = pass_start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  cpbf_bitmap #(
    .MemDepth (MemDepth)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_o (clearing),
    .re_i       (in_accept),
    .raddr_i    (block_index_i),
    .we_i       (s1_adv && s1_q.in_range),
    .waddr_i    (s1_q.block),
    .wdata_i    (final_mask),
    .rdata_o    (stored)
  );

  cpbf_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (s1_adv),
    .stage_i       (s1_q),
    .stored_i      (stored),
    .combine_i     (and_mode_q),
    .final_mask_o  (final_mask),
    .match_mask_o  (match_mask_o),
    .match_count_o (match_count_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/cpbf_lane.sv =====
// ----------------------------------------------------------------------------
// cpbf_lane
// Ordered double compare of one column value against the threshold.
// ----------------------------------------------------------------------------
module cpbf_lane (
  input  logic [cpbf_pkg::ValueW-1:0] value_i,
  input  cpbf_pkg::cmp_cfg_t          cfg_i,
  output logic                        match_o
);

  logic [cpbf_pkg::ValueW-1:0] key;
  logic                        v_nan;

  assign key   = cpbf_pkg::order_key(value_i);
  assign v_nan = cpbf_pkg::is_nan(value_i);

  always_comb begin
    if (v_nan || cfg_i.nan) begin
      match_o = 1'b0;
    end else if (cfg_i.equal_mode) begin
      match_o = (key == cfg_i.key);
    end else begin
      match_o = (key > cfg_i.key);
    end
  end

endmodule

// ===== rtl/cpbf_bitmap.sv =====
// ----------------------------------------------------------------------------
// cpbf_bitmap
// Row bitmap memory with a clearing sweep after reset and write forwarding.
// ----------------------------------------------------------------------------
module cpbf_bitmap #(
  parameter int unsigned MemDepth = 8192
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  output logic                                clearing_o,
  input  logic                                re_i,
  input  logic [cpbf_pkg::BlockW-1:0]         raddr_i,
  input  logic                                we_i,
  input  logic [cpbf_pkg::BlockW-1:0]         waddr_i,
  input  logic [cpbf_pkg::Lanes-1:0]          wdata_i,
  output logic [cpbf_pkg::Lanes-1:0]          rdata_o
);

  localparam int unsigned AW = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic [cpbf_pkg::Lanes-1:0] mem [MemDepth];
  logic [cpbf_pkg::Lanes-1:0] rd_q;
  logic [cpbf_pkg::Lanes-1:0] fwd_data_q;
  logic                       fwd_q;
  logic                       clr_q;
  logic [AW-1:0]              clr_cnt_q;
  logic [AW-1:0]              ra;
  logic [AW-1:0]              wa;

  assign ra = raddr_i[AW-1:0];
  assign wa = waddr_i[AW-1:0];
  assign clearing_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(MemDepth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '1;
    end else if (we_i) begin
      mem[wa] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[ra];
    end
  end

  // Same-edge write to the address being read: take the new byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (wa == ra);
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      fwd_data_q <= wdata_i;
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/cpbf_merge.sv =====
// ----------------------------------------------------------------------------
// cpbf_merge
// Combines lane masks with the stored byte when combine_i is set, counts matches, holds the result.
// ----------------------------------------------------------------------------
module cpbf_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  cpbf_pkg::stage_t             stage_i,
  input  logic [cpbf_pkg::Lanes-1:0]   stored_i,
  input  logic                         combine_i,
  output logic [cpbf_pkg::Lanes-1:0]   final_mask_o,
  output logic [cpbf_pkg::Lanes-1:0]   match_mask_o,
  output logic [cpbf_pkg::CountW-1:0]  match_count_o
);

  logic [cpbf_pkg::Lanes-1:0]  stored;
  logic [cpbf_pkg::Lanes-1:0]  fmask;
  logic [3:0]                  ones;
  logic [cpbf_pkg::CountW-1:0] base;
  logic [cpbf_pkg::CountW:0]   sum;
  logic [cpbf_pkg::CountW-1:0] count_d;
  logic [cpbf_pkg::CountW-1:0] count_q;
  logic [cpbf_pkg::Lanes-1:0]  mask_q;

  assign stored = stage_i.in_range ? stored_i : '1;
  assign fmask  = combine_i ? (stage_i.mask & stored) : stage_i.mask;

  always_comb begin
    ones = '0;
    for (int i = 0; i < cpbf_pkg::Lanes; i++) begin
      ones = ones + {3'b000, fmask[i]};
    end
  end

  assign base    = stage_i.pass_start ? '0 : count_q;
  assign sum     = {1'b0, base} + {{(cpbf_pkg::CountW - 3){1'b0}}, ones};
  assign count_d = sum[cpbf_pkg::CountW] ? cpbf_pkg::CountMax : sum[cpbf_pkg::CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mask_q <= fmask;
    end
  end

  assign final_mask_o  = fmask;
  assign match_mask_o  = mask_q;
  assign match_count_o = count_q;

endmodule

// ===== sim/cpbf_checker.sv =====
// ----------------------------------------------------------------------------
// cpbf_checker
// Watches the config, input and result channels of the column predicate
// bitmap filter, predicts mask and running count per block, and compares.
// ----------------------------------------------------------------------------
module cpbf_checker #(
  parameter int unsigned MAX_ROWS = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [cpbf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [cpbf_pkg::BlockW-1:0]    block_index_i,
  input  logic                           pass_start_i,
  input  logic [7:0][63:0]               values_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [7:0]                     match_mask_i,
  input  logic [16:0]                    match_count_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);

  localparam int unsigned MapBytes = MAX_ROWS / 8;

  typedef struct packed {
    logic [7:0]  mask;
    logic [16:0] count;
  } block_result_t;

  block_result_t               pending_results[$];
  logic [7:0]                  row_map [MapBytes];
  logic [cpbf_pkg::ValueW-1:0] thr_bits;
  logic                        eq_mode;
  logic                        and_mode;
  logic [16:0]                 run_count;

  function automatic logic nan_bits(input logic [63:0] x);
    return (x & cpbf_pkg::MagMask) > cpbf_pkg::ExpAll;
  endfunction

  function automatic logic [63:0] sort_key(input logic [63:0] x);
    logic [63:0] z;
    z = ((x & cpbf_pkg::MagMask) == '0) ? '0 : x;
    return z[63] ? ~z : (z | cpbf_pkg::SignBit);
  endfunction

  function automatic logic lane_hit(input logic [63:0] v);
    if (nan_bits(v) || nan_bits(thr_bits)) return 1'b0;
    if (eq_mode) return sort_key(v) == sort_key(thr_bits);
    return sort_key(v) > sort_key(thr_bits);
  endfunction

  assign outstanding_o = pending_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    block_result_t exp_r;
    logic [7:0]    m;
    logic          in_map;
    int            ones;
    int            total;
    if (!rst_ni) begin
      for (int i = 0; i < MapBytes; i++) row_map[i] = 8'hFF;
      thr_bits = '0;
      eq_mode = 1'b0;
      and_mode = 1'b0;
      run_count = '0;
      pending_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("ERROR: unexpected result mask=%h count=%0d", match_mask_i, match_count_i);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.mask !== match_mask_i || exp_r.count !== match_count_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("ERROR: mask exp %h got %h, count exp %0d got %0d",
                       exp_r.mask, match_mask_i, exp_r.count, match_count_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        m = '0;
        for (int i = 0; i < 8; i++) m[i] = lane_hit(values_i[i]);
        in_map = block_index_i < MapBytes;
        if (and_mode) m &= in_map ? row_map[block_index_i] : 8'hFF;
        if (in_map) row_map[block_index_i] = m;
        if (pass_start_i) run_count = '0;
        ones = $countones(m);
        total = run_count + ones;
        run_count = (total > cpbf_pkg::CountMax) ? cpbf_pkg::CountMax : total[16:0];
        exp_r.mask = m;
        exp_r.count = run_count;
        pending_results.push_back(exp_r);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cpbf_pkg::RegThreshold: thr_bits = cfg_data_i;
          cpbf_pkg::RegCompare:   eq_mode = cfg_data_i[0];
          cpbf_pkg::RegCombine:   and_mode = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sim/column_predicate_bitmap_filter_tb.sv =====
// ----------------------------------------------------------------------------
// column_predicate_bitmap_filter_tb
// Drives directed and random blocks of doubles through the filter under
// several threshold and mode settings with random idling on both sides;
// the checker predicts every mask and count and reports mismatches.
// ----------------------------------------------------------------------------
module column_predicate_bitmap_filter_tb;

  localparam logic [cpbf_pkg::CfgIndexW-1:0] RegSpare = 2'd3;
  localparam int WatchLimit = 30000;
  localparam logic [63:0] DblOne   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] PosZero  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NegZero  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosInf   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInf   = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QuietNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SigNan   = 64'h7FF0_0000_0000_0001;
  localparam logic [63:0] NegNan   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MaxNorm  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinSub   = 64'h0000_0000_0000_0001;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [cpbf_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [63:0]                    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic [cpbf_pkg::BlockW-1:0]    block_index = '0;
  logic                           pass_start = 1'b0;
  logic [7:0][63:0]               vals = '0;
  logic                           out_stall = 1'b0;
  logic                           cfg_ready, in_stall, out_valid;
  logic [7:0]                     match_mask;
  logic [16:0]                    match_count;
  int                             fail_count, outstanding;
  int                             tx_idle_pct = 0, rx_idle_pct = 0;
  int                             hold_left = 0;
  int                             quiet_cycles = 0;
  logic [63:0]                    cur_thr = '0;

  column_predicate_bitmap_filter dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .block_index_i(block_index), .pass_start_i(pass_start),
    .value0_i(vals[0]), .value1_i(vals[1]), .value2_i(vals[2]), .value3_i(vals[3]),
    .value4_i(vals[4]), .value5_i(vals[5]), .value6_i(vals[6]), .value7_i(vals[7]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .match_mask_o(match_mask), .match_count_o(match_count)
  );

  cpbf_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .block_index_i(block_index), .pass_start_i(pass_start), .values_i(vals),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .match_mask_i(match_mask), .match_count_i(match_count),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rx_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [cpbf_pkg::CfgIndexW-1:0] idx,
                           input logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cpbf_pkg::RegThreshold) cur_thr = data;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_block(input logic [cpbf_pkg::BlockW-1:0] blk, input logic ps,
                            input logic [7:0][63:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    block_index <= blk;
    pass_start <= ps;
    vals <= v;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic logic [63:0] pick_double(input logic [63:0] thr);
    case ($urandom_range(13))
      0: return PosZero;
      1: return NegZero;
      2: return PosInf;
      3: return NegInf;
      4: return QuietNan;
      5: return {1'($urandom_range(1)), 11'h7FF, 51'h1} | 64'({$urandom});
      6: return thr;
      7: return thr + 64'd1;
      8: return thr - 64'd1;
      9: return thr ^ cpbf_pkg::SignBit;
      10: return MaxNorm;
      11: return MinSub;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0][63:0] rand_lanes(input logic [63:0] thr);
    logic [7:0][63:0] v;
    for (int i = 0; i < 8; i++) v[i] = pick_double(thr);
    return v;
  endfunction

  function automatic logic [cpbf_pkg::BlockW-1:0] rand_block;
    case ($urandom_range(9))
      0: return '1;
      1: return cpbf_pkg::BlockW'($urandom);
      default: return cpbf_pkg::BlockW'($urandom_range(15));
    endcase
  endfunction

  initial begin
    logic [63:0] thr;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(cpbf_pkg::RegThreshold, DblOne);
    write_reg(RegSpare, '1);
    send_block(13'd0, 1'b1, {MaxNorm, MinSub, PosInf, NegInf, QuietNan, NegZero, PosZero,
                             DblOne + 64'd1});
    send_block('1, 1'b0, {8{64'hFFFF_FFFF_FFFF_FFFF}});
    send_block('1, 1'b0, {8{64'h0000_0000_0000_0000}});
    send_block(13'd1, 1'b0, {8{PosInf}});
    send_block(13'd2, 1'b0, {DblOne, DblOne - 64'd1, DblOne + 64'd1, SigNan, NegNan,
                             64'h7FFF_FFFF_FFFF_FFFF, MaxNorm, NegInf});
    drain();
    write_reg(cpbf_pkg::RegCompare, 64'd1);
    write_reg(cpbf_pkg::RegThreshold, PosZero);
    send_block(13'd3, 1'b1, {PosZero, NegZero, MinSub, NegZero, QuietNan, PosZero, DblOne,
                             MinSub | cpbf_pkg::SignBit});
    drain();
    write_reg(cpbf_pkg::RegThreshold, NegZero);
    send_block(13'd3, 1'b0, {NegZero, PosZero, NegZero, PosZero, NegZero, PosZero, NegZero,
                             PosZero});
    drain();
    write_reg(cpbf_pkg::RegThreshold, QuietNan);
    send_block(13'd4, 1'b0, {8{QuietNan}});
    drain();
    write_reg(cpbf_pkg::RegCompare, 64'd0);
    send_block(13'd4, 1'b0, {8{PosInf}});
    drain();
    write_reg(cpbf_pkg::RegThreshold, NegInf);
    write_reg(cpbf_pkg::RegCombine, 64'd1);
    send_block(13'd0, 1'b0, {8{DblOne}});
    send_block(13'd0, 1'b1, {8{PosZero}});
    send_block(13'd5, 1'b0, {8{NegInf}});
    send_block('1, 1'b0, {8{MaxNorm}});
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 81 : 0;
      rx_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 38 : 0;
      for (int s = 0; s < 4; s++) begin
        drain();
        case ($urandom_range(4))
          0: thr = DblOne;
          1: thr = PosZero;
          2: thr = NegZero;
          3: thr = pick_double(DblOne);
          default: thr = {$urandom, $urandom};
        endcase
        write_reg(cpbf_pkg::RegThreshold, thr);
        write_reg(cpbf_pkg::RegCompare, 64'(s & 1));
        write_reg(cpbf_pkg::RegCombine, 64'((s >> 1) & 1));
        if (phase == 2 && s == 0) hold_left = 400;
        for (int n = 0; n < 115; n++)
          send_block(rand_block(), $urandom_range(19) == 0, rand_lanes(cur_thr));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
